// ===== src/hrht_pkg.sv =====
// shared types, codes and character helpers for the http response header tokenizer
// no dependencies; imported by hrht_step, http_response_header_tokenizer and the testbench
`timescale 1ns / 1ps

package hrht_pkg;

    // parse phases
    typedef enum logic [3:0] {
        PH_VER0  = 4'd0,
        PH_VER   = 4'd1,
        PH_CODE0 = 4'd2,
        PH_CODE  = 4'd3,
        PH_MSG0  = 4'd4,
        PH_MSG   = 4'd5,
        PH_SKIP  = 4'd6,
        PH_NAME0 = 4'd7,
        PH_NAME  = 4'd8,
        PH_VAL0  = 4'd9,
        PH_VAL   = 4'd10,
        PH_CRLF  = 4'd11
    } phase_t;

    // token kinds
    typedef enum logic [3:0] {
        TK_SKIP    = 4'd0,
        TK_VERSION = 4'd1,
        TK_CODE    = 4'd2,
        TK_REASON  = 4'd3,
        TK_REASONE = 4'd4,
        TK_NAME    = 4'd5,
        TK_VALUE   = 4'd6,
        TK_PAIREND = 4'd7,
        TK_HEADEND = 4'd8
    } token_kind_t;

    localparam logic [7:0]  CH_LF    = 8'h0A;
    localparam logic [7:0]  CH_CR    = 8'h0D;
    localparam logic [7:0]  CH_COLON = 8'h3A;
    localparam logic [7:0]  CH_ZERO  = 8'h30;
    localparam logic [7:0]  CH_NINE  = 8'h39;
    localparam logic [7:0]  CH_SPACE = 8'h20;
    localparam logic [7:0]  CH_TAB   = 8'h09;
    localparam logic [15:0] CODE_MAX = 16'hFFFF;

    // result of one tokenizer step
    typedef struct packed {
        phase_t      phase_next;
        logic [15:0] accum_next;
        token_kind_t kind;
        logic [7:0]  tok_byte;
        logic [15:0] shown;
    } step_t;

    // c locale whitespace: space, tab through carriage return
    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ===== src/hrht_step.sv =====
// combinational next-phase and token logic for one input byte
// depends on hrht_pkg
`timescale 1ns / 1ps

module hrht_step
    import hrht_pkg::*;
(
    input  phase_t      phase,
    input  logic [15:0] accum,
    input  logic [7:0]  in_byte,
    output step_t       step
);

    logic [3:0]  digit;
    logic [19:0] accum_x10;
    logic        ws;
    logic        dig;

    assign digit     = 4'(in_byte - CH_ZERO);
    // times ten plus the digit, as two shifts and two adds
    assign accum_x10 = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0} + {16'h0000, digit};
    assign ws        = is_ws(in_byte);
    assign dig       = is_dig(in_byte);

    always_comb
    begin
        logic carry;
        logic clear;
        carry           = 1'b0;
        clear           = 1'b0;
        step.phase_next = phase;
        step.accum_next = accum;
        step.kind       = TK_SKIP;

        unique case (phase)
            PH_VER:
            begin
                if (ws)
                    step.phase_next = PH_CODE0;
                else
                begin
                    step.kind = TK_VERSION;
                    carry     = 1'b1;
                end
            end
            PH_CODE0:
            begin
                if (dig)
                begin
                    step.accum_next = {12'h000, digit};
                    step.phase_next = PH_CODE;
                end
            end
            PH_CODE:
            begin
                if (dig)
                    step.accum_next = (accum_x10 > {4'h0, CODE_MAX}) ? CODE_MAX
                                                                      : accum_x10[15:0];
                else
                begin
                    step.kind       = TK_CODE;
                    step.phase_next = ws ? PH_MSG0 : PH_SKIP;
                end
            end
            PH_MSG0:
            begin
                if (in_byte != CH_LF)
                begin
                    step.kind       = TK_REASON;
                    carry           = 1'b1;
                    step.phase_next = PH_MSG;
                end
            end
            PH_MSG:
            begin
                if (in_byte == CH_LF)
                begin
                    step.kind       = TK_REASONE;
                    step.phase_next = PH_NAME0;
                end
                else if (in_byte == CH_CR)
                begin
                    step.kind       = TK_REASONE;
                    step.phase_next = PH_CRLF;
                end
                else
                begin
                    step.kind = TK_REASON;
                    carry     = 1'b1;
                end
            end
            PH_SKIP, PH_CRLF:
            begin
                if (in_byte == CH_LF)
                    step.phase_next = PH_NAME0;
            end
            PH_NAME0:
            begin
                if (in_byte == CH_LF)
                begin
                    step.kind       = TK_HEADEND;
                    clear           = 1'b1;
                    step.phase_next = PH_VER0;
                end
                else if (!ws)
                begin
                    step.kind       = TK_NAME;
                    carry           = 1'b1;
                    step.phase_next = PH_NAME;
                end
            end
            PH_NAME:
            begin
                if (in_byte == CH_COLON)
                    step.phase_next = PH_VAL0;
                else
                begin
                    step.kind = TK_NAME;
                    carry     = 1'b1;
                end
            end
            PH_VAL0:
            begin
                if (in_byte == CH_LF)
                begin
                    step.kind       = TK_PAIREND;
                    step.phase_next = PH_NAME0;
                end
                else if (!ws)
                begin
                    step.kind       = TK_VALUE;
                    carry           = 1'b1;
                    step.phase_next = PH_VAL;
                end
            end
            PH_VAL:
            begin
                if (in_byte == CH_LF)
                begin
                    step.kind       = TK_PAIREND;
                    step.phase_next = PH_NAME0;
                end
                else if (in_byte == CH_CR)
                begin
                    step.kind       = TK_PAIREND;
                    step.phase_next = PH_CRLF;
                end
                else
                begin
                    step.kind = TK_VALUE;
                    carry     = 1'b1;
                end
            end
            default:
            begin
                // version start and unused codes
                if (!ws)
                begin
                    step.kind       = TK_VERSION;
                    carry           = 1'b1;
                    step.phase_next = PH_VER;
                end
            end
        endcase

        // head end shows the finished code, then clears it
        step.shown    = step.accum_next;
        if (clear)
            step.accum_next = '0;
        step.tok_byte = carry ? in_byte : 8'h00;
    end

endmodule

// ===== src/http_response_header_tokenizer.sv =====
// http response head tokenizer: one byte in, one token out per transaction
// a token is registered and valid in the cycle after its byte is accepted
// throughput: one byte per cycle unless a stalled output holds in_ready low; phase and code registers close the loop
// in_ready stays high while the output register is empty or being drained
// reset (rst_n low, asynchronous): version start phase, code cleared, output empty
`timescale 1ns / 1ps

module http_response_header_tokenizer
    import hrht_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // byte input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    // token output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  token_kind,
    output logic [7:0]  token_byte,
    output logic [15:0] status_code
);

    // parser state
    phase_t      phase_reg;
    logic [15:0] accum_reg;

    // output register
    logic        out_valid_reg;
    token_kind_t kind_reg;
    logic [7:0]  byte_reg;
    logic [15:0] code_reg;

    step_t       step;
    logic        in_fire;

    // the output register takes a new token whenever it is empty or drains
    // this cycle, so a waiting token never blocks a new byte for more than
    // the cycles the consumer stalls
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // per-byte phase machine and code accumulator update
    hrht_step u_step
    (
        .phase   (phase_reg),
        .accum   (accum_reg),
        .in_byte (in_byte),
        .step    (step)
    );

    // parser state moves only on an accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_VER0;
            accum_reg <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= step.phase_next;
            accum_reg <= step.accum_next;
        end
    end

    // output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg <= step.kind;
            byte_reg <= step.tok_byte;
            code_reg <= step.shown;
        end
    end

    assign out_valid   = out_valid_reg;
    assign token_kind  = kind_reg;
    assign token_byte  = byte_reg;
    assign status_code = code_reg;

    // a token that carries no byte shows zero in token_byte
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == TK_SKIP || kind_reg == TK_CODE ||
                           kind_reg == TK_REASONE || kind_reg == TK_PAIREND ||
                           kind_reg == TK_HEADEND)) |-> (byte_reg == 8'h00))
        else $error("token_byte nonzero for a kind without byte");

    // head end returns the parser to its start with the code cleared
    a_head_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && step.kind == TK_HEADEND) |=> (phase_reg == PH_VER0 && accum_reg == 16'h0000))
        else $error("parser not restarted after head end");

    // parser state holds when no byte is accepted
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> ($stable(phase_reg) && $stable(accum_reg)))
        else $error("parser state changed without an accepted byte");

    // a stalled token is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while output stalled");

endmodule

// ===== tb/tb_http_response_header_tokenizer.sv =====
// self-checking testbench for http_response_header_tokenizer: a directed table of head bytes
// then random well-formed and broken heads; tokens checked against the table or a local model
// depends on hrht_pkg (phase and token kind enums, character constants) and the tokenizer rtl
`timescale 1ns / 1ps

module tb_http_response_header_tokenizer;
    import hrht_pkg::*;

    // one token as it leaves the block
    typedef struct packed {
        token_kind_t kind;
        logic [7:0]  tbyte;
        logic [15:0] code;
    } token_t;

    // one row of the directed table; want is used only where typed is set
    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        token_t     want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 28;
    localparam int RANDOM_BYTES  = 750;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  token_kind;
    logic [7:0]  token_byte;
    logic [15:0] status_code;

    // local copy of the tokenizer state
    phase_t      model_phase;
    logic [15:0] model_code;

    token_t      pending_tokens[$];
    stim_row_t   directed_rows[DIRECTED_ROWS];
    logic [7:0]  head_bytes[$];
    int          mismatches = 0;

    // when set, that side of the handshake runs without idle cycles
    bit          in_steady  = 0;
    bit          out_steady = 0;

    http_response_header_tokenizer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .token_kind  (token_kind),
        .token_byte  (token_byte),
        .status_code (status_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("tb_http_response_header_tokenizer NOT OK");
        $finish;
    end

    // c locale whitespace: space and tab through carriage return
    function automatic bit blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit decimal(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // advance the local state by one byte and return the token it produces
    function automatic token_t next_token(input logic [7:0] c);
        token_t      t;
        bit          carry;
        bit          clear;
        int unsigned wide;
        t.kind = TK_SKIP;
        carry  = 1'b0;
        clear  = 1'b0;
        case (model_phase)
            PH_VER:
            begin
                if (blank(c))
                    model_phase = PH_CODE0;
                else
                begin
                    t.kind = TK_VERSION;
                    carry  = 1'b1;
                end
            end
            PH_CODE0:
            begin
                if (decimal(c))
                begin
                    model_code  = {8'h00, c - CH_ZERO};
                    model_phase = PH_CODE;
                end
            end
            PH_CODE:
            begin
                if (decimal(c))
                begin
                    wide       = model_code * 10 + (c - CH_ZERO);
                    model_code = (wide > 65535) ? CODE_MAX : wide[15:0];
                end
                else
                begin
                    t.kind      = TK_CODE;
                    model_phase = blank(c) ? PH_MSG0 : PH_SKIP;
                end
            end
            PH_MSG0:
            begin
                if (c != CH_LF)
                begin
                    t.kind      = TK_REASON;
                    carry       = 1'b1;
                    model_phase = PH_MSG;
                end
            end
            PH_MSG:
            begin
                if (c == CH_LF)
                begin
                    t.kind      = TK_REASONE;
                    model_phase = PH_NAME0;
                end
                else if (c == CH_CR)
                begin
                    t.kind      = TK_REASONE;
                    model_phase = PH_CRLF;
                end
                else
                begin
                    t.kind = TK_REASON;
                    carry  = 1'b1;
                end
            end
            PH_SKIP, PH_CRLF:
            begin
                if (c == CH_LF)
                    model_phase = PH_NAME0;
            end
            PH_NAME0:
            begin
                if (c == CH_LF)
                begin
                    t.kind      = TK_HEADEND;
                    clear       = 1'b1;
                    model_phase = PH_VER0;
                end
                else if (!blank(c))
                begin
                    t.kind      = TK_NAME;
                    carry       = 1'b1;
                    model_phase = PH_NAME;
                end
            end
            PH_NAME:
            begin
                if (c == CH_COLON)
                    model_phase = PH_VAL0;
                else
                begin
                    t.kind = TK_NAME;
                    carry  = 1'b1;
                end
            end
            PH_VAL0:
            begin
                // lf right after the colon ends the pair with an empty value
                if (c == CH_LF)
                begin
                    t.kind      = TK_PAIREND;
                    model_phase = PH_NAME0;
                end
                else if (!blank(c))
                begin
                    t.kind      = TK_VALUE;
                    carry       = 1'b1;
                    model_phase = PH_VAL;
                end
            end
            PH_VAL:
            begin
                if (c == CH_LF)
                begin
                    t.kind      = TK_PAIREND;
                    model_phase = PH_NAME0;
                end
                else if (c == CH_CR)
                begin
                    t.kind      = TK_PAIREND;
                    model_phase = PH_CRLF;
                end
                else
                begin
                    t.kind = TK_VALUE;
                    carry  = 1'b1;
                end
            end
            default:
            begin
                if (!blank(c))
                begin
                    t.kind      = TK_VERSION;
                    carry       = 1'b1;
                    model_phase = PH_VER;
                end
            end
        endcase
        t.tbyte = carry ? c : 8'h00;
        t.code  = model_code;
        // head end still shows the finished code, then the accumulator clears
        if (clear)
            model_code = 16'h0000;
        return t;
    endfunction

    function automatic stim_row_t stim(input logic [7:0] b, input logic typed,
                                       input token_kind_t kind, input logic [7:0] tbyte,
                                       input logic [15:0] code);
        stim_row_t r;
        r.b          = b;
        r.typed      = typed;
        r.want.kind  = kind;
        r.want.tbyte = tbyte;
        r.want.code  = code;
        return r;
    endfunction

    // mostly printable, sometimes space or a high byte; never cr or lf
    function automatic logic [7:0] text_byte();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 8'($urandom_range(8'h80, 8'hFF));
        else if (r == 1)
            return 8'h20;
        else
            return 8'($urandom_range(8'h21, 8'h7E));
    endfunction

    // any whitespace byte, space and tab through carriage return equally likely
    function automatic logic [7:0] blank_byte();
        int r;
        r = $urandom_range(0, 5);
        return (r == 0) ? 8'h20 : 8'(8'h08 + r);
    endfunction

    // drive one byte after a random gap, hold it until taken, then record its token
    task automatic send_byte(input logic [7:0] b, input logic typed, input token_t want);
        int     gap;
        token_t guess;
        if ($urandom_range(0, 39) == 0)
            in_steady = !in_steady;
        gap = in_steady ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        // inputs and outputs are settled at the falling edge; the transaction
        // happens at the next rising edge
        do
            @(negedge clk);
        while (in_ready !== 1'b1);
        guess = next_token(b);
        pending_tokens.push_back(typed ? want : guess);
        @(posedge clk);
    endtask

    // build one response head into head_bytes: mostly well formed with random
    // content, some pure noise, and a few corrupted bytes sprinkled in
    task automatic compose_head();
        int         n;
        int         k;
        logic [7:0] b;
        string      ver;
        head_bytes.delete();
        if ($urandom_range(0, 99) < 12)
        begin
            n = $urandom_range(4, 24);
            repeat (n) head_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end

        // version word, sometimes after leading whitespace
        if ($urandom_range(0, 3) == 0)
            head_bytes.push_back(blank_byte());
        if ($urandom_range(0, 1) == 1)
        begin
            ver = "HTTP/1.1";
            for (k = 0; k < ver.len(); k++)
                head_bytes.push_back(ver[k]);
        end
        else
        begin
            n = $urandom_range(1, 8);
            repeat (n)
            begin
                do
                    b = text_byte();
                while (blank(b));
                head_bytes.push_back(b);
            end
        end
        head_bytes.push_back(blank_byte());

        // status code, sometimes with junk before the first digit, sometimes long enough
        // to saturate
        if ($urandom_range(0, 7) == 0)
            head_bytes.push_back(text_byte());
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 3;
        repeat (n) head_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));

        // reason phrase, or a malformed code terminator that skips to lf
        if ($urandom_range(0, 9) == 0)
        begin
            do
                b = text_byte();
            while (blank(b) || decimal(b));
            head_bytes.push_back(b);
            n = $urandom_range(0, 5);
            repeat (n) head_bytes.push_back(text_byte());
        end
        else
        begin
            head_bytes.push_back(($urandom_range(0, 5) == 0) ? blank_byte() : 8'h20);
            n = $urandom_range(0, 10);
            repeat (n) head_bytes.push_back(text_byte());
            if ($urandom_range(0, 3) != 0)
                head_bytes.push_back(CH_CR);
        end
        head_bytes.push_back(CH_LF);

        // header pairs
        n = $urandom_range(0, 4);
        repeat (n)
        begin
            do
                b = text_byte();
            while (blank(b) || b == CH_COLON);
            head_bytes.push_back(b);
            k = $urandom_range(0, 6);
            repeat (k)
            begin
                do
                    b = text_byte();
                while (b == CH_COLON);
                head_bytes.push_back(b);
            end
            head_bytes.push_back(CH_COLON);
            if ($urandom_range(0, 1) == 1)
                head_bytes.push_back(8'h20);
            k = $urandom_range(0, 8);
            repeat (k) head_bytes.push_back(text_byte());
            if ($urandom_range(0, 3) != 0)
                head_bytes.push_back(CH_CR);
            head_bytes.push_back(CH_LF);
        end

        // empty line ends the head
        if ($urandom_range(0, 1) == 1)
            head_bytes.push_back(CH_CR);
        head_bytes.push_back(CH_LF);

        // occasional corruption of single bytes
        foreach (head_bytes[i])
            if ($urandom_range(0, 99) < 3)
                head_bytes[i] = 8'($urandom_range(0, 255));
    endtask

    // token side: random stalls, every transaction compared with the oldest expectation
    initial
    begin
        int     stall;
        token_t want;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                out_steady = !out_steady;
            stall = out_steady ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(negedge clk);
            while (out_valid !== 1'b1);
            if (pending_tokens.size() == 0)
            begin
                $error("token_kind: no token expected, actual %0d", token_kind);
                mismatches++;
            end
            else
            begin
                want = pending_tokens.pop_front();
                if (token_kind !== want.kind)
                begin
                    $error("token_kind: expected %0d, actual %0d", want.kind, token_kind);
                    mismatches++;
                end
                if (token_byte !== want.tbyte)
                begin
                    $error("token_byte: expected %0h, actual %0h", want.tbyte, token_byte);
                    mismatches++;
                end
                if (status_code !== want.code)
                begin
                    $error("status_code: expected %0d, actual %0d", want.code, status_code);
                    mismatches++;
                end
            end
            @(posedge clk);
        end
    end

    // byte side: reset, directed table, random heads, drain and verdict
    initial
    begin
        int sent;
        in_valid    <= 1'b0;
        in_byte     <= 8'h00;
        rst_n       <= 1'b0;
        model_phase = PH_VER0;
        model_code  = 16'h0000;

        // leading blank, byte extremes as version bytes
        directed_rows[0]  = stim(8'h20, 1'b1, TK_SKIP, 8'h00, 16'd0);
        directed_rows[1]  = stim(8'hFF, 1'b1, TK_VERSION, 8'hFF, 16'd0);
        directed_rows[2]  = stim(8'h00, 1'b1, TK_VERSION, 8'h00, 16'd0);
        // tab into code start, then junk that code start ignores
        directed_rows[3]  = stim(8'h09, 1'b0, TK_SKIP, 8'h00, 16'd0);
        directed_rows[4]  = stim("x",   1'b0, TK_SKIP, 8'h00, 16'd0);
        // six nines: the accumulator saturates on the fifth and stays there
        directed_rows[5]  = stim("9",   1'b0, TK_SKIP, 8'h00, 16'd0);
        directed_rows[6]  = stim("9",   1'b0, TK_SKIP, 8'h00, 16'd0);
        directed_rows[7]  = stim("9",   1'b0, TK_SKIP, 8'h00, 16'd0);
        directed_rows[8]  = stim("9",   1'b0, TK_SKIP, 8'h00, 16'd0);
        directed_rows[9]  = stim("9",   1'b0, TK_SKIP, 8'h00, 16'd0);
        directed_rows[10] = stim("9",   1'b1, TK_SKIP, 8'h00, 16'hFFFF);
        directed_rows[11] = stim(8'h20, 1'b1, TK_CODE, 8'h00, 16'hFFFF);
        // lf at reason start is skipped, then a reason ended by cr
        directed_rows[12] = stim(CH_LF, 1'b0, TK_SKIP, 8'h00, 16'd0);
        directed_rows[13] = stim("O",   1'b0, TK_SKIP, 8'h00, 16'd0);
        directed_rows[14] = stim(CH_CR, 1'b0, TK_SKIP, 8'h00, 16'd0);
        directed_rows[15] = stim(8'hFF, 1'b0, TK_SKIP, 8'h00, 16'd0);
        directed_rows[16] = stim(CH_LF, 1'b0, TK_SKIP, 8'h00, 16'd0);
        // colon opening a name, lf inside a name, then an empty value
        directed_rows[17] = stim(CH_COLON, 1'b0, TK_SKIP, 8'h00, 16'd0);
        directed_rows[18] = stim(CH_LF, 1'b0, TK_SKIP, 8'h00, 16'd0);
        directed_rows[19] = stim(CH_COLON, 1'b0, TK_SKIP, 8'h00, 16'd0);
        directed_rows[20] = stim(CH_LF, 1'b1, TK_PAIREND, 8'h00, 16'hFFFF);
        // ordinary pair with a value ended by cr lf
        directed_rows[21] = stim("A",   1'b0, TK_SKIP, 8'h00, 16'd0);
        directed_rows[22] = stim(CH_COLON, 1'b0, TK_SKIP, 8'h00, 16'd0);
        directed_rows[23] = stim(8'h20, 1'b0, TK_SKIP, 8'h00, 16'd0);
        directed_rows[24] = stim("v",   1'b0, TK_SKIP, 8'h00, 16'd0);
        directed_rows[25] = stim(CH_CR, 1'b0, TK_SKIP, 8'h00, 16'd0);
        directed_rows[26] = stim(CH_LF, 1'b0, TK_SKIP, 8'h00, 16'd0);
        // empty line: head end still carries the saturated code
        directed_rows[27] = stim(CH_LF, 1'b1, TK_HEADEND, 8'h00, 16'hFFFF);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].want);

        // random heads until enough bytes have gone in; the last head is sent whole
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            compose_head();
            foreach (head_bytes[i])
                send_byte(head_bytes[i], 1'b0, '0);
            sent += head_bytes.size();
        end
        in_valid <= 1'b0;

        // drain, then a few cycles more so a stray extra token would be caught
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("tb_http_response_header_tokenizer OK");
        else
            $display("tb_http_response_header_tokenizer NOT OK");
        $finish;
    end

endmodule
